/* hw/rtl/aedd_pkg.sv */
// Package for the Atkinson dither block: field widths, register codes,
// line store word layout, position flags and the clamped-add helper.
// No dependencies.
package aedd_pkg;

  // field widths
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned DELTA_W    = 5;
  localparam int unsigned WIDTH_W    = 11;
  localparam int unsigned HEIGHT_W   = 13;
  localparam int unsigned ROW_W      = 12;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned WORD_W     = 2 * DELTA_W;

  // register reset values and bounds
  localparam logic [WIDTH_W-1:0]  WIDTH_RST    = 11'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST   = 13'd480;
  localparam logic [HEIGHT_W-1:0] HEIGHT_LIMIT = 13'd4096;

  // threshold and full-scale level
  localparam logic [CHAN_W-1:0] BLACK_MAX = 8'd127;
  localparam logic [CHAN_W:0]   PIX_MAX   = 9'd255;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  // one line store entry: delta of row y-1 and of row y-2 for a column
  typedef struct packed {
    logic signed [DELTA_W-1:0] prev;
    logic signed [DELTA_W-1:0] older;
  } word_t;

  // which neighbor sources exist for the current pixel
  typedef struct packed {
    logic has_x1;
    logic has_x2;
    logic has_y1;
    logic has_y2;
    logic last_col;
    logic last_row;
  } pos_flags_t;

  // add a signed delta and clamp to 0..255
  function automatic logic [CHAN_W-1:0] add_clamp(input logic [CHAN_W-1:0] v,
                                                  input logic [DELTA_W-1:0] d);
    logic [CHAN_W+1:0] s;
    s = {2'b00, v} + {{(CHAN_W + 2 - DELTA_W){d[DELTA_W-1]}}, d};
    if (s[CHAN_W+1]) begin
      return '0;
    end else if (s[CHAN_W]) begin
      return '1;
    end else begin
      return s[CHAN_W-1:0];
    end
  endfunction

  // largest of three channels
  function automatic logic [CHAN_W-1:0] max3(input logic [CHAN_W-1:0] a,
                                             input logic [CHAN_W-1:0] b,
                                             input logic [CHAN_W-1:0] c);
    logic [CHAN_W-1:0] m;
    m = (a > b) ? a : b;
    return (c > m) ? c : m;
  endfunction

endpackage

/* hw/rtl/aedd_if.sv */
// Stream interfaces of the dither block: RGB pixel input and
// black/white pixel output, each with valid/ready. Uses aedd_pkg.
interface aedd_rgb_if import aedd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;

  modport source(output valid, red, green, blue, input ready);
  modport sink(input valid, red, green, blue, output ready);
endinterface

interface aedd_bw_if ();
  logic valid;
  logic ready;
  logic pixel_white;
  logic end_of_frame;

  modport source(output valid, pixel_white, end_of_frame, input ready);
  modport sink(input valid, pixel_white, end_of_frame, output ready);
endinterface

/* hw/rtl/aedd_ram.sv */
// Generic RAM: one write port, two registered read ports with a shared
// read enable; a read of the address being written returns the new data.
// No dependencies.
module aedd_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read ports with write-through
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= (we_i && (waddr_i == raddr_a_i)) ? wdata_i : mem_q[raddr_a_i];
      rdata_b_o <= (we_i && (waddr_i == raddr_b_i)) ? wdata_i : mem_q[raddr_b_i];
    end
  end

endmodule

/* hw/rtl/aedd_pos.sv */
// Frame geometry registers and column/row counters of the dither block.
// Gives the position and edge flags of the next pixel transaction. Uses aedd_pkg.
module aedd_pos import aedd_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 1024,
  localparam int unsigned AW = $clog2(MAX_WIDTH)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  accept_i,
  output logic [AW-1:0]         x_o,
  output logic [AW-1:0]         x_next_o,
  output pos_flags_t            flags_o
);

  localparam int unsigned CMPW = (AW + 1 > WIDTH_W) ? AW + 1 : WIDTH_W;

  logic [WIDTH_W-1:0]  width_q;
  logic [HEIGHT_W-1:0] height_q;
  logic [AW-1:0]       col_q;
  logic [ROW_W-1:0]    row_q;

  logic [CMPW-1:0]     width_ext;
  logic [CMPW-1:0]     w_eff;
  logic [CMPW-1:0]     x_inc;
  logic [HEIGHT_W-1:0] h_eff;
  logic [HEIGHT_W-1:0] y_inc;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_FRAME_WIDTH:  width_q  <= cfg_data_i[WIDTH_W-1:0];
        REG_FRAME_HEIGHT: height_q <= cfg_data_i[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // effective frame size: zero reads as one, saturate at the bounds
  always_comb begin
    width_ext = CMPW'(width_q);
    if (width_ext == '0) begin
      w_eff = CMPW'(1);
    end else if (width_ext > CMPW'(MAX_WIDTH)) begin
      w_eff = CMPW'(MAX_WIDTH);
    end else begin
      w_eff = width_ext;
    end
    if (height_q == '0) begin
      h_eff = HEIGHT_W'(1);
    end else if (height_q > HEIGHT_LIMIT) begin
      h_eff = HEIGHT_LIMIT;
    end else begin
      h_eff = height_q;
    end
  end

  // edge flags of the current position
  always_comb begin
    x_inc            = CMPW'(col_q) + CMPW'(1);
    y_inc            = HEIGHT_W'(row_q) + HEIGHT_W'(1);
    flags_o.has_x1   = (col_q != '0);
    flags_o.has_x2   = (col_q[AW-1:1] != '0);
    flags_o.has_y1   = (row_q != '0);
    flags_o.has_y2   = (row_q[ROW_W-1:1] != '0);
    flags_o.last_col = (x_inc >= w_eff);
    flags_o.last_row = (y_inc >= h_eff);
  end

  assign x_o      = col_q;
  assign x_next_o = x_inc[AW-1:0];

  // position counters, advanced per transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept_i) begin
      if (flags_o.last_col) begin
        col_q <= '0;
        row_q <= flags_o.last_row ? '0 : y_inc[ROW_W-1:0];
      end else begin
        col_q <= x_inc[AW-1:0];
      end
    end
  end

  // column wraps at the row end
  a_col_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && flags_o.last_col |=> col_q == '0)
    else $error("column counter did not wrap at row end");

  // column steps by one inside a row
  a_col_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && !flags_o.last_col |=> col_q == $past(col_q) + AW'(1))
    else $error("column counter did not advance");

  // frame end returns to the top row
  a_row_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && flags_o.last_col && flags_o.last_row |=> row_q == '0)
    else $error("row counter did not wrap at frame end");

endmodule

/* hw/rtl/aedd_diffuse.sv */
// Pixel stage and result register of the dither block: applies the stored
// deltas, thresholds, writes the new delta back to the line store.
// Uses aedd_pkg and the stream interfaces of aedd_if.
module aedd_diffuse import aedd_pkg::*; #(
  parameter int unsigned AW = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  aedd_rgb_if.sink   rgb_i,
  aedd_bw_if.source  bw_o,
  input  pos_flags_t flags_i,
  input  logic [AW-1:0] x_i,
  output logic       accept_o,
  input  word_t      word_a_i,
  input  word_t      word_b_i,
  output logic       we_o,
  output logic [AW-1:0] waddr_o,
  output word_t      wdata_o
);

  logic              s1_valid_q;
  logic [CHAN_W-1:0] s1_red_q;
  logic [CHAN_W-1:0] s1_green_q;
  logic [CHAN_W-1:0] s1_blue_q;
  pos_flags_t        s1_flags_q;
  logic [AW-1:0]     s1_x_q;
  logic              s1_fire;

  logic [DELTA_W-1:0] left_one_q;
  logic [DELTA_W-1:0] left_two_q;
  logic [DELTA_W-1:0] left_prev_q;

  logic out_valid_q;
  logic out_white_q;
  logic out_eof_q;

  logic [CHAN_W-1:0]  v0, v1, v2, v3, v4, v5, v6;
  logic               white;
  logic [CHAN_W:0]    err;
  logic [DELTA_W-1:0] delta;

  // handshake: stage moves when the result register is free or drains
  assign s1_fire     = s1_valid_q && (!out_valid_q || bw_o.ready);
  assign rgb_i.ready = !s1_valid_q || s1_fire;
  assign accept_o    = rgb_i.valid && rgb_i.ready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept_o) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_o) begin
      s1_red_q   <= rgb_i.red;
      s1_green_q <= rgb_i.green;
      s1_blue_q  <= rgb_i.blue;
      s1_flags_q <= flags_i;
      s1_x_q     <= x_i;
    end
  end

  // diffusion sum in raster order of the sources, clamped per add
  always_comb begin
    v0 = max3(s1_red_q, s1_green_q, s1_blue_q);
    v1 = s1_flags_q.has_y2 ? add_clamp(v0, word_b_i.older) : v0;
    v2 = (s1_flags_q.has_y1 && s1_flags_q.has_x1) ? add_clamp(v1, left_prev_q) : v1;
    v3 = s1_flags_q.has_y1 ? add_clamp(v2, word_b_i.prev) : v2;
    v4 = (s1_flags_q.has_y1 && !s1_flags_q.last_col) ? add_clamp(v3, word_a_i.prev) : v3;
    v5 = s1_flags_q.has_x2 ? add_clamp(v4, left_two_q) : v4;
    v6 = s1_flags_q.has_x1 ? add_clamp(v5, left_one_q) : v5;
  end

  // threshold and quantization error, delta is error shifted right by 3
  always_comb begin
    white = (v6 > BLACK_MAX);
    err   = white ? ({1'b0, v6} - PIX_MAX) : {1'b0, v6};
    delta = err[DELTA_W+2:3];
  end

  // line store update: new delta for this row, old one moves to row y-2
  assign we_o          = s1_fire;
  assign waddr_o       = s1_x_q;
  assign wdata_o.prev  = delta;
  assign wdata_o.older = word_b_i.prev;

  // deltas of the left neighbors, cleared at the row end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_one_q <= '0;
      left_two_q <= '0;
    end else if (s1_fire) begin
      if (s1_flags_q.last_col) begin
        left_one_q <= '0;
        left_two_q <= '0;
      end else begin
        left_two_q <= left_one_q;
        left_one_q <= delta;
      end
    end
  end

  // row y-1 delta of the previous column
  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      left_prev_q <= word_b_i.prev;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (bw_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_white_q <= white;
      out_eof_q   <= s1_flags_q.last_col && s1_flags_q.last_row;
    end
  end

  assign bw_o.valid        = out_valid_q;
  assign bw_o.pixel_white  = out_white_q;
  assign bw_o.end_of_frame = out_eof_q;

  // left deltas are clear after a row end
  a_left_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && s1_flags_q.last_col |=> left_one_q == '0 && left_two_q == '0)
    else $error("left deltas not cleared at row end");

  // a stalled pixel keeps its slot and position
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_fire |=> s1_valid_q && $stable(s1_x_q))
    else $error("stalled pixel lost or changed");

  // frame end marker follows the pixel that closes the frame
  a_eof: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> out_valid_q &&
      out_eof_q == $past(s1_flags_q.last_col && s1_flags_q.last_row))
    else $error("frame end marker mismatch");

endmodule

/* hw/rtl/atkinson_error_diffusion_dither_top.sv */
// Atkinson dither, RGB stream in, one black/white pixel out per pixel.
// Takes one pixel per clock cycle while the output is not stalled; a taken
// pixel is held in the input register of the pixel stage, and its result is
// registered in an output register, where it is held while the next pixel
// is worked on. The deltas are kept in the line store: a RAM of MAX_WIDTH
// words of two 5-bit deltas (rows y-1 and y-2), read at two columns when a
// pixel is taken and written once when it leaves the pixel stage. The store
// has no reset and no clearing pass; entries outside the written frame area
// are never used. Uses aedd_pkg, aedd_if, aedd_pos, aedd_ram, aedd_diffuse.
module atkinson_error_diffusion_dither_top import aedd_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  aedd_rgb_if.sink              rgb_i,
  aedd_bw_if.source             bw_o
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);

  logic          accept;
  logic [AW-1:0] x;
  logic [AW-1:0] x_next;
  pos_flags_t    flags;
  word_t         word_a;
  word_t         word_b;
  logic          we;
  logic [AW-1:0] waddr;
  word_t         wdata;

  // position and geometry
  aedd_pos #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_pos (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .x_o        (x),
    .x_next_o   (x_next),
    .flags_o    (flags)
  );

  // line store: port b reads this column, port a the one to the right
  aedd_ram #(
    .WIDTH(WORD_W),
    .DEPTH(MAX_WIDTH)
  ) u_line (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .re_i      (accept),
    .raddr_a_i (x_next),
    .raddr_b_i (x),
    .rdata_a_o (word_a),
    .rdata_b_o (word_b)
  );

  // pixel stage and result register
  aedd_diffuse #(
    .AW(AW)
  ) u_diffuse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rgb_i    (rgb_i),
    .bw_o     (bw_o),
    .flags_i  (flags),
    .x_i      (x),
    .accept_o (accept),
    .word_a_i (word_a),
    .word_b_i (word_b),
    .we_o     (we),
    .waddr_o  (waddr),
    .wdata_o  (wdata)
  );

endmodule
